### design/player_serial_frame_engine_defines.svh
// Assertion macros shared by the frame engine modules.
`ifndef PLAYER_SERIAL_FRAME_ENGINE_DEFINES_SVH
`define PLAYER_SERIAL_FRAME_ENGINE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PSFE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle.
`define PSFE_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### design/psfe_pkg.sv
package psfe_pkg;

	localparam logic [7:0] SyncByte    = 8'h7E;
	localparam logic [7:0] VersionByte = 8'hFF;
	localparam logic [7:0] LengthByte  = 8'h06;
	localparam logic [7:0] EndByte     = 8'hEF;
	localparam logic [15:0] SumBase    = 16'h0105;
	localparam logic [7:0] ResendCmd   = 8'h40;
	localparam logic [7:0] ResendParam = 8'h04;
	localparam logic [31:0] NakPayload = 32'h4000_0006;
	localparam logic [3:0] LastFrameIdx = 4'd9;

	typedef enum logic [3:0] {
		DF_WAIT_VER  = 4'd0,
		DF_WAIT_LEN  = 4'd1,
		DF_TAKE_CMD  = 4'd2,
		DF_TAKE_ACK  = 4'd3,
		DF_TAKE_P1   = 4'd4,
		DF_TAKE_P2   = 4'd5,
		DF_CHK_HI    = 4'd6,
		DF_CHK_LO    = 4'd7,
		DF_WAIT_END  = 4'd8
	} deframe_state_t;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  rx_byte;
		logic [31:0] tx_payload;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] tx_byte;
		logic       last_of_run;
		logic [7:0] rx_command;
		logic       rx_feedback;
		logic [7:0] rx_param_high;
		logic [7:0] rx_param_low;
	} out_item_t;

	// Work handed from the deframer to the frame sender.
	typedef struct packed {
		logic        is_report;
		logic [31:0] payload;
		logic [15:0] check;
	} job_t;

	function automatic logic [15:0] frame_check(input logic [31:0] p);
		logic [15:0] sum;
		sum = SumBase + {8'h00, p[31:24]} + {8'h00, p[23:16]}
			+ {8'h00, p[15:8]} + {8'h00, p[7:0]};
		return 16'h0000 - sum;
	endfunction

	function automatic logic [7:0] frame_byte(input job_t j, input logic [3:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0: b = SyncByte;
			4'd1: b = VersionByte;
			4'd2: b = LengthByte;
			4'd3: b = j.payload[31:24];
			4'd4: b = j.payload[23:16];
			4'd5: b = j.payload[15:8];
			4'd6: b = j.payload[7:0];
			4'd7: b = j.check[15:8];
			4'd8: b = j.check[7:0];
			default: b = EndByte;
		endcase
		return b;
	endfunction

endpackage

### design/psfe_front.sv
module psfe_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  psfe_pkg::in_item_t   item,
	output logic                 job_valid,
	output psfe_pkg::job_t       job
);

	psfe_pkg::deframe_state_t state_q, state_d, state_eff;
	logic [7:0]  command_q, param_high_q, param_low_q;
	logic        feedback_q;
	logic [31:0] last_q;
	logic [15:0] expect_check;
	logic [7:0]  rx;
	logic        send_frame;
	logic [31:0] send_payload;

	assign rx = item.rx_byte;
	assign expect_check = psfe_pkg::frame_check({command_q, 7'd0, feedback_q,
		param_high_q, param_low_q});
	assign state_eff = (rx == psfe_pkg::SyncByte) ? psfe_pkg::DF_WAIT_VER : state_q;

	// Next deframer state.
	always_comb begin
		state_d = state_q;
		if (!item.cmd) begin
			unique case (state_eff)
				psfe_pkg::DF_WAIT_LEN: state_d = (rx == psfe_pkg::LengthByte) ?
					psfe_pkg::DF_TAKE_CMD : psfe_pkg::DF_WAIT_VER;
				psfe_pkg::DF_TAKE_CMD: state_d = psfe_pkg::DF_TAKE_ACK;
				psfe_pkg::DF_TAKE_ACK: state_d = (rx[7:1] == 7'd0) ?
					psfe_pkg::DF_TAKE_P1 : psfe_pkg::DF_WAIT_VER;
				psfe_pkg::DF_TAKE_P1: state_d = psfe_pkg::DF_TAKE_P2;
				psfe_pkg::DF_TAKE_P2: state_d = psfe_pkg::DF_CHK_HI;
				psfe_pkg::DF_CHK_HI: state_d = (rx == expect_check[15:8]) ?
					psfe_pkg::DF_CHK_LO : psfe_pkg::DF_WAIT_VER;
				psfe_pkg::DF_CHK_LO: state_d = (rx == expect_check[7:0]) ?
					psfe_pkg::DF_WAIT_END : psfe_pkg::DF_WAIT_VER;
				psfe_pkg::DF_WAIT_END: state_d = psfe_pkg::DF_WAIT_VER;
				default: state_d = (rx == psfe_pkg::VersionByte) ?
					psfe_pkg::DF_WAIT_LEN : psfe_pkg::DF_WAIT_VER;
			endcase
		end
	end

	// Classify the item into a job.
	always_comb begin
		job_valid    = 1'b0;
		send_frame   = 1'b0;
		send_payload = last_q;
		job.is_report = 1'b0;
		job.payload   = {command_q, 7'd0, feedback_q, param_high_q, param_low_q};
		if (item.cmd) begin
			send_frame   = 1'b1;
			send_payload = item.tx_payload;
		end else begin
			unique case (state_eff)
				psfe_pkg::DF_CHK_HI: if (rx != expect_check[15:8]) begin
					send_frame   = 1'b1;
					send_payload = psfe_pkg::NakPayload;
				end
				psfe_pkg::DF_CHK_LO: if (rx != expect_check[7:0]) begin
					send_frame   = 1'b1;
					send_payload = psfe_pkg::NakPayload;
				end
				psfe_pkg::DF_WAIT_END: if (rx == psfe_pkg::EndByte) begin
					if (command_q == psfe_pkg::ResendCmd
						&& param_low_q == psfe_pkg::ResendParam) begin
						send_frame = 1'b1;
					end else begin
						job_valid     = 1'b1;
						job.is_report = 1'b1;
					end
				end
				default: ;
			endcase
		end
		if (send_frame) begin
			job_valid   = 1'b1;
			job.payload = send_payload;
		end
		job.check = psfe_pkg::frame_check(send_payload);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= psfe_pkg::DF_WAIT_VER;
			command_q    <= 8'd0;
			feedback_q   <= 1'b0;
			param_high_q <= 8'd0;
			param_low_q  <= 8'd0;
			last_q       <= 32'd0;
		end else if (take) begin
			state_q <= state_d;
			if (send_frame) begin
				last_q <= send_payload;
			end
			if (!item.cmd) begin
				unique case (state_eff)
					psfe_pkg::DF_TAKE_CMD: command_q <= rx;
					psfe_pkg::DF_TAKE_ACK: if (rx[7:1] == 7'd0) begin
						feedback_q <= rx[0];
					end
					psfe_pkg::DF_TAKE_P1: param_high_q <= rx;
					psfe_pkg::DF_TAKE_P2: param_low_q <= rx;
					default: ;
				endcase
			end
		end
	end

endmodule

### design/psfe_job_queue.sv
`include "player_serial_frame_engine_defines.svh"

module psfe_job_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  psfe_pkg::job_t  push_job,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output psfe_pkg::job_t  head
);

	psfe_pkg::job_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`PSFE_ASSERT(a_count_range, count_q != 2'd3, "job queue count out of range")
	`PSFE_ASSERT(a_no_overflow, !(push && full && !pop), "job queue overflow")
	`PSFE_ASSERT(a_no_underflow, !(pop && !not_empty), "job queue underflow")

endmodule

### design/psfe_back.sv
`include "player_serial_frame_engine_defines.svh"

module psfe_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_ready,
	input  psfe_pkg::job_t       job_head,
	output logic                 job_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output psfe_pkg::out_item_t  out_data
);

	psfe_pkg::job_t      job_q, src;
	psfe_pkg::out_item_t out_q, gen;
	logic       busy_q, out_valid_q;
	logic [3:0] idx_q, idx;
	logic       advance, gen_valid;

	assign advance   = !out_valid_q || out_ready;
	assign gen_valid = busy_q || job_ready;
	assign job_pop   = advance && !busy_q && job_ready;
	assign src       = busy_q ? job_q : job_head;
	assign idx       = busy_q ? idx_q : 4'd0;

	always_comb begin
		gen = '0;
		if (src.is_report && !busy_q) begin
			gen.kind          = 1'b1;
			gen.last_of_run   = 1'b1;
			gen.rx_command    = src.payload[31:24];
			gen.rx_feedback   = src.payload[16];
			gen.rx_param_high = src.payload[15:8];
			gen.rx_param_low  = src.payload[7:0];
		end else begin
			gen.tx_byte     = psfe_pkg::frame_byte(src, idx);
			gen.last_of_run = (idx == psfe_pkg::LastFrameIdx);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= gen;
		end
		if (job_pop) begin
			job_q <= job_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			idx_q       <= 4'd0;
		end else if (advance) begin
			out_valid_q <= gen_valid;
			if (busy_q) begin
				idx_q <= idx_q + 4'd1;
				if (idx_q == psfe_pkg::LastFrameIdx) begin
					busy_q <= 1'b0;
				end
			end else if (job_pop && !job_head.is_report) begin
				busy_q <= 1'b1;
				idx_q  <= 4'd1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PSFE_ASSERT(a_idx_range, !busy_q || (idx_q != 4'd0 && idx_q <= psfe_pkg::LastFrameIdx),
		"frame byte index out of range")
	`PSFE_ASSERT(a_report_last, !(out_valid_q && out_q.kind) || out_q.last_of_run,
		"report without end of run")
	`PSFE_ASSERT_NEXT(a_frame_end, busy_q && advance && idx_q == psfe_pkg::LastFrameIdx,
		out_valid_q && out_q.last_of_run && !busy_q, "frame end byte not flagged")

endmodule

### design/player_serial_frame_engine.sv
// Serial frame engine for a small audio player module.
// Input channel (in_valid/in_ready/in_data): each beat is either one byte
// received from the UART (cmd 0) or a four-byte send request (cmd 1).
// Output channel (out_valid/out_ready/out_data): each beat is one transmit
// byte (kind 0) or one received-frame report (kind 1); last_of_run marks
// the final beat caused by one input beat.
// A send request, a checksum failure (NAK) or a resend request yields ten
// transmit beats, one per cycle from the sender while out_ready holds;
// a good frame yields one report; other received bytes yield nothing.
// Each job is registered in the job queue and then in the output register
// before its first beat shows. Input throughput is one beat per cycle while
// the two-entry job queue has room; the sender's ten-beat frame loop sets
// the sustained rate when frames are requested back to back.
// Reset clears the deframer to waiting for the version byte, the held
// fields and the last sent payload to zero, and empties queue and output.
// When the receiver stalls, the output beat holds, the sender halts, the
// queue fills and in_ready drops; received bytes that cause no output
// still pass while the queue is not full.
module player_serial_frame_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  psfe_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output psfe_pkg::out_item_t  out_data
);

	logic           take;
	logic           job_valid, queue_full, queue_ready, job_pop;
	psfe_pkg::job_t new_job, head_job;

	// Take a beat whenever the queue can absorb whatever job it makes.
	assign in_ready = !queue_full;
	assign take     = in_valid && in_ready;

	psfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (in_data),
		.job_valid (job_valid),
		.job       (new_job)
	);

	psfe_job_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && job_valid),
		.push_job  (new_job),
		.pop       (job_pop),
		.full      (queue_full),
		.not_empty (queue_ready),
		.head      (head_job)
	);

	psfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_ready (queue_ready),
		.job_head  (head_job),
		.job_pop   (job_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
